/* rtl/dbd_pkg.sv */
// ----------------------------------------------------------------------------
// dbd_pkg
// Shared types, constants and helpers of the detection box decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dbd_pkg;

  localparam int MAX_CLASSES = 80;
  localparam int CORNER_ROW_LEN = 6;
  localparam int CENTER_MIN_LEN = 5;

  typedef enum logic [2:0] {
    REG_FORMAT_MODE     = 3'd0,
    REG_SCORE_THRESHOLD = 3'd1,
    REG_INVERSE_SCALE   = 3'd2,
    REG_PAD_LEFT        = 3'd3,
    REG_PAD_TOP         = 3'd4,
    REG_FRAME_WIDTH     = 3'd5,
    REG_FRAME_HEIGHT    = 3'd6
  } reg_idx_t;

  localparam logic MODE_CORNER = 1'b0;
  localparam logic MODE_CENTER = 1'b1;

  typedef enum logic [2:0] {
    CAT_PERSON  = 3'd0,
    CAT_VEHICLE = 3'd1,
    CAT_ANIMAL  = 3'd2,
    CAT_CAT     = 3'd3,
    CAT_DOG     = 3'd4,
    CAT_OTHER   = 3'd5
  } category_t;

  typedef struct packed {
    logic        format_mode;
    logic [16:0] score_threshold;
    logic [23:0] inverse_scale;
    logic [11:0] pad_left;
    logic [11:0] pad_top;
    logic [13:0] frame_width;
    logic [13:0] frame_height;
  } cfg_t;

  typedef struct packed {
    logic [3:0][31:0] box;
    logic             mode;
    logic [6:0]       class_index;
    logic [31:0]      score;
  } job_t;

  function automatic category_t category_of(input logic [6:0] c);
    category_t cat;
    cat = CAT_OTHER;
    if (c == 7'd0) cat = CAT_PERSON;
    else if (c == 7'd1 || c == 7'd2 || c == 7'd3 || c == 7'd5 || c == 7'd7) cat = CAT_VEHICLE;
    else if (c == 7'd15) cat = CAT_CAT;
    else if (c == 7'd16) cat = CAT_DOG;
    else if (c == 7'd14 || (c >= 7'd17 && c <= 7'd23)) cat = CAT_ANIMAL;
    return cat;
  endfunction

endpackage

`default_nettype wire

/* rtl/dbd_front.sv */
// ----------------------------------------------------------------------------
// dbd_front
// Row parser: collects box values, tracks score and class, queues kept rows.
// ----------------------------------------------------------------------------
`default_nettype none

module dbd_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire dbd_pkg::cfg_t       cfg,
  input  wire logic                accept,
  input  wire logic signed [31:0]  element_value,
  input  wire logic                row_end,
  output dbd_pkg::job_t            job,
  output logic                     push
);

  logic [7:0]        pos_r, pos_nxt;
  logic [31:0]       score_r, score_nxt;
  logic [6:0]        class_r, class_nxt;
  logic              cvalid_r, cvalid_nxt;
  logic [3:0][31:0]  box_r;

  logic [32:0]       abs_v;
  logic [16:0]       mag;
  logic              cls_ok;
  logic              keep;
  logic signed [32:0] score_ext;
  logic signed [32:0] thr_ext;
  logic [7:0]        cls_pos;

  always_comb begin
    abs_v     = element_value[31] ? (33'd0 - {element_value[31], element_value})
                                  : {1'b0, element_value};
    mag       = abs_v[32:16];
    cls_ok    = element_value[31] ? (mag == 17'd0)
                                  : (mag < 17'(dbd_pkg::MAX_CLASSES));
    cls_pos   = pos_r - 8'd4;
    score_nxt = score_r;
    class_nxt = class_r;
    cvalid_nxt = cvalid_r;
    if (pos_r >= 8'd4) begin
      if (cfg.format_mode == dbd_pkg::MODE_CORNER) begin
        if (pos_r == 8'd4) begin
          score_nxt = element_value;
        end else if (pos_r == 8'd5) begin
          cvalid_nxt = cls_ok;
          class_nxt  = cls_ok ? mag[6:0] : 7'd0;
        end
      end else begin
        if (pos_r == 8'd4) begin
          score_nxt = element_value;
          class_nxt = 7'd0;
        end else if (pos_r < 8'(4 + dbd_pkg::MAX_CLASSES) &&
                     $signed(element_value) > $signed(score_r)) begin
          score_nxt = element_value;
          class_nxt = cls_pos[6:0];
        end
      end
    end
    if (row_end) pos_nxt = 8'd0;
    else if (pos_r != 8'd255) pos_nxt = pos_r + 8'd1;
    else pos_nxt = pos_r;
    score_ext = {score_nxt[31], score_nxt};
    thr_ext   = {16'd0, cfg.score_threshold};
    if (cfg.format_mode == dbd_pkg::MODE_CORNER)
      keep = (pos_r >= 8'(dbd_pkg::CORNER_ROW_LEN - 1)) && cvalid_nxt;
    else
      keep = pos_r >= 8'(dbd_pkg::CENTER_MIN_LEN - 1);
    keep = keep && !(score_ext < thr_ext);
    push = accept && row_end && keep;
    job.box         = box_r;
    job.mode        = cfg.format_mode;
    job.class_index = class_nxt;
    job.score       = score_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= 8'd0;
      score_r  <= 32'd0;
      class_r  <= 7'd0;
      cvalid_r <= 1'b0;
    end else if (accept) begin
      pos_r    <= pos_nxt;
      score_r  <= score_nxt;
      class_r  <= class_nxt;
      cvalid_r <= cvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && pos_r < 8'd4) begin
      box_r[pos_r[1:0]] <= element_value;
    end
  end

endmodule

`default_nettype wire

/* rtl/dbd_queue.sv */
// ----------------------------------------------------------------------------
// dbd_queue
// Two-entry request queue between the row parser and the box mapper.
// ----------------------------------------------------------------------------
`default_nettype none

module dbd_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire dbd_pkg::job_t  push_job,
  input  wire logic           pop,
  output dbd_pkg::job_t       head_job,
  output logic                head_valid,
  output logic                full
);

  dbd_pkg::job_t entry_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    count_r;

  assign head_job   = entry_r[rd_ptr_r];
  assign head_valid = count_r != 2'd0;
  assign full       = count_r == 2'd2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_job;
  end

endmodule

`default_nettype wire

/* rtl/dbd_back.sv */
// ----------------------------------------------------------------------------
// dbd_back
// Box mapper: un-letterboxes and clamps four corners through one multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module dbd_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire dbd_pkg::cfg_t  cfg,
  input  wire dbd_pkg::job_t  head_job,
  input  wire logic           head_valid,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [13:0]         out_box_left,
  output logic [13:0]         out_box_top,
  output logic [13:0]         out_box_width,
  output logic [13:0]         out_box_height,
  output logic [2:0]          out_category,
  output logic [6:0]          out_class_index,
  output logic signed [31:0]  out_confidence
);

  logic        adv;
  logic        issue;
  logic [1:0]  idx_r;

  logic               a_valid_r;
  logic [1:0]         a_idx_r;
  logic signed [34:0] a_twice_r;
  logic [6:0]         a_class_r;
  logic [31:0]        a_score_r;

  logic               b_valid_r;
  logic [1:0]         b_idx_r;
  logic [40:0]        b_val_r;
  logic [6:0]         b_class_r;
  logic [31:0]        b_score_r;

  logic               c_done_r;
  logic [29:0]        coord_r [4];
  logic [6:0]         c_class_r;
  logic [31:0]        c_score_r;

  logic               out_valid_r;

  logic [1:0]         base_sel;
  logic [1:0]         off_sel;
  logic [31:0]        base_v;
  logic [31:0]        off_v;
  logic signed [34:0] base_s;
  logic signed [34:0] off_s;
  logic signed [34:0] pad_s;
  logic signed [34:0] twice;
  logic [57:0]        prod;
  logic [29:0]        lim;
  logic [29:0]        clamped;
  logic [29:0]        dx;
  logic [29:0]        dy;

  assign adv       = !out_valid_r || !out_stall;
  assign issue     = adv && head_valid;
  assign pop       = issue && idx_r == 2'd3;
  assign out_valid = out_valid_r;

  always_comb begin
    if (head_job.mode == dbd_pkg::MODE_CENTER) begin
      base_sel = {1'b0, idx_r[0]};
      off_sel  = idx_r[1] ? idx_r : {1'b1, idx_r[0]};
    end else begin
      base_sel = idx_r;
      off_sel  = idx_r;
    end
    base_v = head_job.box[base_sel];
    off_v  = head_job.box[off_sel];
    base_s = {{2{base_v[31]}}, base_v, 1'b0};
    if (head_job.mode == dbd_pkg::MODE_CENTER)
      off_s = idx_r[1] ? {{3{off_v[31]}}, off_v} : -{{3{off_v[31]}}, off_v};
    else
      off_s = 35'sd0;
    pad_s = idx_r[0] ? {6'd0, cfg.pad_top, 17'd0} : {6'd0, cfg.pad_left, 17'd0};
    twice = base_s + off_s - pad_s;
  end

  assign prod = a_twice_r[33:0] * cfg.inverse_scale;

  always_comb begin
    lim     = b_idx_r[0] ? {cfg.frame_height, 16'd0} : {cfg.frame_width, 16'd0};
    clamped = (b_val_r > {11'd0, lim}) ? lim : b_val_r[29:0];
    dx      = (coord_r[2] > coord_r[0]) ? coord_r[2] - coord_r[0] : 30'd0;
    dy      = (coord_r[3] > coord_r[1]) ? coord_r[3] - coord_r[1] : 30'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_done_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      if (issue) idx_r <= idx_r + 2'd1;
      a_valid_r   <= issue;
      b_valid_r   <= a_valid_r;
      c_done_r    <= b_valid_r && b_idx_r == 2'd3;
      out_valid_r <= c_done_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_idx_r   <= idx_r;
      a_twice_r <= twice;
      a_class_r <= head_job.class_index;
      a_score_r <= head_job.score;
      b_idx_r   <= a_idx_r;
      b_val_r   <= (a_twice_r > 35'sd0) ? prod[57:17] : 41'd0;
      b_class_r <= a_class_r;
      b_score_r <= a_score_r;
      if (b_valid_r) coord_r[b_idx_r] <= clamped;
      c_class_r <= b_class_r;
      c_score_r <= b_score_r;
      if (c_done_r) begin
        out_box_left    <= coord_r[0][29:16];
        out_box_top     <= coord_r[1][29:16];
        out_box_width   <= dx[29:16];
        out_box_height  <= dy[29:16];
        out_category    <= dbd_pkg::category_of(c_class_r);
        out_class_index <= c_class_r;
        out_confidence  <= c_score_r;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/detection_box_decode.sv */
// ----------------------------------------------------------------------------
// detection_box_decode
// Decodes streamed detector rows into clamped boxes on the original frame.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one row value per request (in_element_value) with
//   in_row_end on the last value of a row. A kept row yields one result request
//   on the out_ channel; dropped rows yield nothing.
//   The cfg_ port writes one register per cycle; the user must write it only
//   while the block is idle, which the block itself leaves unchecked.
// Throughput: one input value per cycle while in_stall is low. A kept row
//   occupies the shared multiplier once per corner, and every kept row spans
//   at least five input values, so without output stalls it runs without pause.
// Reset: synchronous, active low; clears row state, queue and output valid and
//   loads the register defaults (corner mode, threshold 0.5, unit scale, no
//   padding, 640 x 640 frame).
// Stall: a stalled result holds; the mapper pipeline freezes behind it and the
//   two-entry queue absorbs kept rows until full, then in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module detection_box_decode (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [23:0]         cfg_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic signed [31:0]  in_element_value,
  input  wire logic                in_row_end,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [13:0]              out_box_left,
  output logic [13:0]              out_box_top,
  output logic [13:0]              out_box_width,
  output logic [13:0]              out_box_height,
  output logic [2:0]               out_category,
  output logic [6:0]               out_class_index,
  output logic signed [31:0]       out_confidence
);

  dbd_pkg::cfg_t cfg_r;
  dbd_pkg::job_t push_job;
  dbd_pkg::job_t head_job;
  logic          push;
  logic          pop;
  logic          head_valid;
  logic          full;
  logic          accept;

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.format_mode     <= dbd_pkg::MODE_CORNER;
      cfg_r.score_threshold <= 17'd32768;
      cfg_r.inverse_scale   <= 24'd65536;
      cfg_r.pad_left        <= 12'd0;
      cfg_r.pad_top         <= 12'd0;
      cfg_r.frame_width     <= 14'd640;
      cfg_r.frame_height    <= 14'd640;
    end else if (cfg_we) begin
      unique case (dbd_pkg::reg_idx_t'(cfg_index))
        dbd_pkg::REG_FORMAT_MODE:     cfg_r.format_mode     <= cfg_data[0];
        dbd_pkg::REG_SCORE_THRESHOLD: cfg_r.score_threshold <= cfg_data[16:0];
        dbd_pkg::REG_INVERSE_SCALE:   cfg_r.inverse_scale   <= cfg_data[23:0];
        dbd_pkg::REG_PAD_LEFT:        cfg_r.pad_left        <= cfg_data[11:0];
        dbd_pkg::REG_PAD_TOP:         cfg_r.pad_top         <= cfg_data[11:0];
        dbd_pkg::REG_FRAME_WIDTH:     cfg_r.frame_width     <= cfg_data[13:0];
        dbd_pkg::REG_FRAME_HEIGHT:    cfg_r.frame_height    <= cfg_data[13:0];
        default:                      cfg_r                 <= cfg_r;
      endcase
    end
  end

  dbd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .accept        (accept),
    .element_value (in_element_value),
    .row_end       (in_row_end),
    .job           (push_job),
    .push          (push)
  );

  dbd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .head_job   (head_job),
    .head_valid (head_valid),
    .full       (full)
  );

  dbd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .head_job        (head_job),
    .head_valid      (head_valid),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_box_left    (out_box_left),
    .out_box_top     (out_box_top),
    .out_box_width   (out_box_width),
    .out_box_height  (out_box_height),
    .out_category    (out_category),
    .out_class_index (out_class_index),
    .out_confidence  (out_confidence)
  );

endmodule

`default_nettype wire

/* tb/detection_box_decode_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// detection_box_decode_tb
// Self-checking testbench for the detection box decoder. Detector rows are
// streamed one value per request in corner and center form. A short stimulus
// table with hand-worked boxes comes first, then random rows under a series of
// register settings, with random gaps on the input and random output stalls.
// Every box is checked against a cycle-free model of the row decode,
// un-letterbox and clamp arithmetic kept inside this testbench.
// ----------------------------------------------------------------------------

module detection_box_decode_tb;

  localparam int CLK_HALF = 5;
  localparam int RANDOM_VALUES = 950;
  localparam int QUIET_FROM = 800;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PLAN_ROWS = 8;

  typedef struct packed {
    logic [13:0]         box_left;
    logic [13:0]         box_top;
    logic [13:0]         box_width;
    logic [13:0]         box_height;
    dbd_pkg::category_t  category;
    logic [6:0]          class_index;
    logic signed [31:0]  confidence;
  } box_result_t;

  typedef struct packed {
    logic             is_setting;
    dbd_pkg::cfg_t    setting;
    logic [2:0]       len;
    logic [5:0][31:0] vals;
    logic             typed;
    logic             want_kept;
    box_result_t      want;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [23:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] in_element_value = '0;
  logic               in_row_end = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [13:0]        out_box_left;
  logic [13:0]        out_box_top;
  logic [13:0]        out_box_width;
  logic [13:0]        out_box_height;
  logic [2:0]         out_category;
  logic [6:0]         out_class_index;
  logic signed [31:0] out_confidence;

  dbd_pkg::cfg_t cfg_now;
  logic [7:0]  row_pos = '0;
  longint      held_score = 0;
  logic [6:0]  held_class = '0;
  longint      corner_vals [4];
  bit          class_ok = 1'b0;

  box_result_t pending_boxes [$];
  box_result_t head_box;
  box_result_t seen_box;
  plan_row_t   plan [PLAN_ROWS];

  int errors = 0;
  int values_sent = 0;
  int boxes_checked = 0;
  int rows_dropped = 0;
  int settings_used = 0;
  int in_gap_pct = 0;
  int out_stall_pct = 0;
  int cycle_count = 0;

  detection_box_decode uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_element_value (in_element_value),
    .in_row_end       (in_row_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_box_left     (out_box_left),
    .out_box_top      (out_box_top),
    .out_box_width    (out_box_width),
    .out_box_height   (out_box_height),
    .out_category     (out_category),
    .out_class_index  (out_class_index),
    .out_confidence   (out_confidence)
  );

  assign seen_box = {out_box_left, out_box_top, out_box_width, out_box_height,
                     out_category, out_class_index, out_confidence};

  always #CLK_HALF clk = ~clk;

  function automatic logic [31:0] q16(input int px);
    return 32'(px * 65536);
  endfunction

  function automatic dbd_pkg::category_t class_group(input logic [6:0] c);
    case (c)
      7'd0: return dbd_pkg::CAT_PERSON;
      7'd1, 7'd2, 7'd3, 7'd5, 7'd7: return dbd_pkg::CAT_VEHICLE;
      7'd15: return dbd_pkg::CAT_CAT;
      7'd16: return dbd_pkg::CAT_DOG;
      7'd14, 7'd17, 7'd18, 7'd19, 7'd20, 7'd21, 7'd22, 7'd23: return dbd_pkg::CAT_ANIMAL;
      default: return dbd_pkg::CAT_OTHER;
    endcase
  endfunction

  // un-letterbox a doubled coordinate, scale to Q.16 and clamp to the frame
  function automatic longint to_frame(input longint twice, input logic [13:0] bound);
    longint lim;
    longint v;
    lim = longint'(bound) << 16;
    if (twice <= 0) return 0;
    v = (twice * longint'(cfg_now.inverse_scale)) >>> 17;
    return (v > lim) ? lim : v;
  endfunction

  function automatic bit decode_value(input logic signed [31:0] value, input bit last,
                                      output box_result_t r);
    longint sv, mag, px, py, ax, ay, bx, by, x1, y1, x2, y2;
    int pos, count;
    bit keep;
    sv = value;
    pos = row_pos;
    r = '0;
    if (pos < 4) begin
      corner_vals[pos] = sv;
    end else if (cfg_now.format_mode == dbd_pkg::MODE_CORNER) begin
      if (pos == 4) begin
        held_score = sv;
      end else if (pos == 5) begin
        mag = ((sv < 0) ? -sv : sv) >>> 16;
        class_ok = (sv < 0) ? (mag == 0) : (mag < dbd_pkg::MAX_CLASSES);
        held_class = class_ok ? mag[6:0] : '0;
      end
    end else begin
      if (pos == 4) begin
        held_score = sv;
        held_class = '0;
      end else if (pos < 4 + dbd_pkg::MAX_CLASSES && sv > held_score) begin
        held_score = sv;
        held_class = 7'(pos - 4);
      end
    end
    count = pos + 1;
    row_pos = (pos < 255) ? 8'(pos + 1) : 8'd255;
    if (!last) return 1'b0;
    row_pos = '0;
    if (cfg_now.format_mode == dbd_pkg::MODE_CORNER)
      keep = count >= dbd_pkg::CORNER_ROW_LEN && class_ok;
    else keep = count >= dbd_pkg::CENTER_MIN_LEN;
    if (!keep || held_score < longint'(cfg_now.score_threshold)) return 1'b0;
    px = longint'(cfg_now.pad_left) * 131072;
    py = longint'(cfg_now.pad_top) * 131072;
    if (cfg_now.format_mode == dbd_pkg::MODE_CORNER) begin
      ax = 2 * corner_vals[0] - px;
      ay = 2 * corner_vals[1] - py;
      bx = 2 * corner_vals[2] - px;
      by = 2 * corner_vals[3] - py;
    end else begin
      ax = 2 * corner_vals[0] - corner_vals[2] - px;
      ay = 2 * corner_vals[1] - corner_vals[3] - py;
      bx = 2 * corner_vals[0] + corner_vals[2] - px;
      by = 2 * corner_vals[1] + corner_vals[3] - py;
    end
    x1 = to_frame(ax, cfg_now.frame_width);
    y1 = to_frame(ay, cfg_now.frame_height);
    x2 = to_frame(bx, cfg_now.frame_width);
    y2 = to_frame(by, cfg_now.frame_height);
    r.box_left = 14'(x1 >>> 16);
    r.box_top = 14'(y1 >>> 16);
    r.box_width = (x2 > x1) ? 14'((x2 - x1) >>> 16) : '0;
    r.box_height = (y2 > y1) ? 14'((y2 - y1) >>> 16) : '0;
    r.category = class_group(held_class);
    r.class_index = held_class;
    r.confidence = held_score[31:0];
    return 1'b1;
  endfunction

  function automatic plan_row_t row_entry(input int n, input logic [5:0][31:0] vals,
                                          input bit typed, input bit kept,
                                          input box_result_t want);
    plan_row_t p;
    p = '0;
    p.len = 3'(n);
    p.vals = vals;
    p.typed = typed;
    p.want_kept = kept;
    p.want = want;
    return p;
  endfunction

  function automatic plan_row_t setting_entry(input dbd_pkg::cfg_t c);
    plan_row_t p;
    p = '0;
    p.is_setting = 1'b1;
    p.setting = c;
    return p;
  endfunction

  function automatic logic signed [31:0] rand_coord(input bit as_size);
    logic signed [31:0] v;
    case ($urandom_range(0, 7))
      0: v = $urandom();
      1: v = -$signed({4'd0, 12'($urandom_range(0, 300)), 16'($urandom())});
      default: v = {4'd0, 12'($urandom_range(0, 2500)), 16'($urandom())};
    endcase
    if (as_size && $urandom_range(0, 4) == 0) v = -v;
    return v;
  endfunction

  function automatic logic signed [31:0] rand_score();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'(cfg_now.score_threshold) + $urandom_range(0, 2) - 1;
      2, 3: return 32'($urandom_range(0, 4) * 16384);
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  task automatic send_value(input logic signed [31:0] value, input bit last,
                            output bit kept, output box_result_t r);
    if ($urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_element_value <= value;
    in_row_end <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    values_sent++;
    kept = decode_value(value, last, r);
    if (kept) pending_boxes = {pending_boxes, r};
    else if (last) rows_dropped++;
  endtask

  task automatic drain_boxes();
    in_valid <= 1'b0;
    while (pending_boxes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_cfg(input dbd_pkg::cfg_t c);
    dbd_pkg::reg_idx_t idx;
    logic [23:0] d;
    drain_boxes();
    for (int i = 0; i <= int'(dbd_pkg::REG_FRAME_HEIGHT); i++) begin
      idx = dbd_pkg::reg_idx_t'(i);
      case (idx)
        dbd_pkg::REG_FORMAT_MODE:     d = 24'(c.format_mode);
        dbd_pkg::REG_SCORE_THRESHOLD: d = 24'(c.score_threshold);
        dbd_pkg::REG_INVERSE_SCALE:   d = c.inverse_scale;
        dbd_pkg::REG_PAD_LEFT:        d = 24'(c.pad_left);
        dbd_pkg::REG_PAD_TOP:         d = 24'(c.pad_top);
        dbd_pkg::REG_FRAME_WIDTH:     d = 24'(c.frame_width);
        default:                      d = 24'(c.frame_height);
      endcase
      cfg_we <= 1'b1;
      cfg_index <= idx;
      cfg_data <= d;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cfg_now = c;
    settings_used++;
  endtask

  task automatic send_row();
    int len;
    bit corner;
    bit k;
    logic signed [31:0] v;
    box_result_t r;
    corner = cfg_now.format_mode == dbd_pkg::MODE_CORNER;
    if (corner) begin
      case ($urandom_range(0, 19))
        0: len = $urandom_range(1, 5);
        1: len = $urandom_range(7, 12);
        2: len = ($urandom_range(0, 3) == 0) ? 300 : 6;
        default: len = 6;
      endcase
    end else begin
      case ($urandom_range(0, 19))
        0: len = $urandom_range(1, 4);
        1, 2: len = $urandom_range(82, 94);
        3: len = ($urandom_range(0, 3) == 0) ? 300 : 5;
        default: len = $urandom_range(5, 14);
      endcase
    end
    for (int i = 0; i < len; i++) begin
      if (i < 4) begin
        v = rand_coord(!corner && i >= 2);
      end else if (!corner || i == 4) begin
        v = rand_score();
      end else if (i == 5) begin
        case ($urandom_range(0, 9))
          0: v = $urandom();
          1: v = q16($urandom_range(dbd_pkg::MAX_CLASSES, 127)) | $urandom_range(0, 65535);
          2: v = -$signed(32'($urandom_range(0, 65535)));
          3: v = -$signed(q16($urandom_range(1, 100)));
          default: v = q16($urandom_range(0, dbd_pkg::MAX_CLASSES - 1)) |
                       $urandom_range(0, 65535);
        endcase
      end else begin
        v = $urandom();
      end
      send_value(v, i == len - 1, k, r);
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && $urandom_range(0, 99) < out_stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_boxes.size() == 0) begin
        errors++;
        $display("%0t: unexpected box, expected none, actual l=%0d t=%0d w=%0d h=%0d",
                 $time, out_box_left, out_box_top, out_box_width, out_box_height);
      end else begin
        head_box = pending_boxes.pop_front();
        boxes_checked++;
        if (seen_box !== head_box) begin
          errors++;
          $display("%0t: box expected l=%0d t=%0d w=%0d h=%0d cat=%0d cls=%0d conf=%0d",
                   $time, head_box.box_left, head_box.box_top, head_box.box_width,
                   head_box.box_height, head_box.category, head_box.class_index,
                   head_box.confidence);
          $display("%0t: box actual   l=%0d t=%0d w=%0d h=%0d cat=%0d cls=%0d conf=%0d",
                   $time, out_box_left, out_box_top, out_box_width, out_box_height,
                   out_category, out_class_index, out_confidence);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d boxes outstanding", cycle_count,
               pending_boxes.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    dbd_pkg::cfg_t c;
    bit k;
    box_result_t r;
    int phase;
    cfg_now = {dbd_pkg::MODE_CORNER, 17'd32768, 24'd65536, 12'd0, 12'd0, 14'd640, 14'd640};
    foreach (corner_vals[i]) corner_vals[i] = 0;

    plan[0] = row_entry(6, {32'h8000_0000, 32'h0, 32'h7FFF_FFFF, q16(700), 32'd32768,
                            q16(79)}, 1'b1, 1'b1,
                        {14'd0, 14'd0, 14'd640, 14'd640, dbd_pkg::CAT_OTHER, 7'd79,
                         32'sd32768});
    plan[1] = row_entry(2, {q16(5), q16(5), 128'd0}, 1'b1, 1'b0, '0);
    plan[2] = row_entry(6, {q16(1), q16(2), q16(3), q16(4), 32'h7FFF_FFFF, q16(80)},
                        1'b1, 1'b0, '0);
    plan[3] = row_entry(6, {q16(300), q16(10), q16(100), q16(50), 32'd65536,
                            32'hFFFF_8000}, 1'b1, 1'b1,
                        {14'd300, 14'd10, 14'd0, 14'd40, dbd_pkg::CAT_PERSON, 7'd0,
                         32'sd65536});
    plan[4] = setting_entry({dbd_pkg::MODE_CENTER, 17'd32768, 24'd65536, 12'd0, 12'd0,
                             14'd640, 14'd640});
    plan[5] = row_entry(5, {q16(100), q16(100), q16(-50), q16(40), 32'd65536, 32'd0},
                        1'b1, 1'b1,
                        {14'd125, 14'd80, 14'd0, 14'd40, dbd_pkg::CAT_PERSON, 7'd0,
                         32'sd65536});
    plan[6] = setting_entry({dbd_pkg::MODE_CORNER, 17'd65536, 24'hFF_FFFF, 12'd4095,
                             12'd4095, 14'd8192, 14'd8192});
    plan[7] = row_entry(6, {32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'd65536, q16(16) | 32'hE000}, 1'b1, 1'b1,
                        {14'd8192, 14'd8192, 14'd0, 14'd0, dbd_pkg::CAT_DOG, 7'd16,
                         32'sd65536});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_gap_pct = 20;
    out_stall_pct = 20;
    foreach (plan[i]) begin
      if (plan[i].is_setting) begin
        apply_cfg(plan[i].setting);
      end else begin
        for (int j = 0; j < plan[i].len; j++)
          send_value(plan[i].vals[5 - j], j == plan[i].len - 1, k, r);
        if (plan[i].typed && (k != plan[i].want_kept || (k && r !== plan[i].want))) begin
          errors++;
          $display("%0t: worked row %0d, expected kept=%0d box %h, actual kept=%0d box %h",
                   $time, i, plan[i].want_kept, plan[i].want, k, r);
        end
      end
    end

    phase = 0;
    while (values_sent < RANDOM_VALUES) begin
      if (phase == 0) begin
        c = {dbd_pkg::MODE_CORNER, 17'd0, 24'd0, 12'd0, 12'd0, 14'd1, 14'd1};
      end else if (phase == 1) begin
        c = {dbd_pkg::MODE_CENTER, 17'd65536, 24'hFF_FFFF, 12'd4095, 12'd4095, 14'd8192,
             14'd8192};
      end else begin
        c.format_mode = $urandom_range(0, 1);
        case ($urandom_range(0, 3))
          0: c.score_threshold = 17'd0;
          1: c.score_threshold = 17'd65536;
          default: c.score_threshold = 17'($urandom_range(0, 65536));
        endcase
        case ($urandom_range(0, 5))
          0: c.inverse_scale = 24'd0;
          1: c.inverse_scale = 24'hFF_FFFF;
          default: c.inverse_scale = 24'($urandom_range(16384, 196608));
        endcase
        c.pad_left = ($urandom_range(0, 5) == 0) ? 12'd4095 : 12'($urandom_range(0, 120));
        c.pad_top = ($urandom_range(0, 5) == 0) ? 12'd4095 : 12'($urandom_range(0, 120));
        c.frame_width = ($urandom_range(0, 5) == 0) ? 14'd8192
                                                    : 14'($urandom_range(1, 2000));
        c.frame_height = ($urandom_range(0, 5) == 0) ? 14'd8192
                                                     : 14'($urandom_range(1, 2000));
      end
      apply_cfg(c);
      phase++;
      if (values_sent >= QUIET_FROM) begin
        in_gap_pct = 0;
        out_stall_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: in_gap_pct = 0;
          1: in_gap_pct = 15;
          default: in_gap_pct = 40;
        endcase
        case ($urandom_range(0, 2))
          0: out_stall_pct = 0;
          1: out_stall_pct = 15;
          default: out_stall_pct = 40;
        endcase
      end
      repeat ($urandom_range(4, 12)) send_row();
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 5)) send_value(rand_coord(1'b0), 1'b0, k, r);
    end

    drain_boxes();
    $display("Sent %0d row values across %0d register settings in corner and center form",
             values_sent, settings_used);
    $display("Checked %0d boxes; %0d rows were dropped on score, class or length",
             boxes_checked, rows_dropped);
    if (errors == 0 && pending_boxes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
